FILE: rtl/hltp_pkg.sv
// shared types and constants of the linear probing hash table
package hltp_pkg;

  localparam int DEF_TABLE_SIZE = 16;
  localparam int DEF_KEY_BITS   = 16;

  localparam int KEY_FW   = 16;
  localparam int DIV_W    = 5;
  localparam int SLOT_FW  = 4;
  localparam int PROBE_FW = 5;
  localparam int OUT_DW   = 16;

  localparam logic [DIV_W-1:0] DIV_RESET = 5'd13;

  typedef enum logic {
    CMD_INSERT = 1'b0,
    CMD_SEARCH = 1'b1
  } op_t;

  typedef enum logic [1:0] {
    ST_INSERTED  = 2'd0,
    ST_FOUND     = 2'd1,
    ST_NOT_FOUND = 2'd2,
    ST_FULL      = 2'd3
  } status_t;

  // commands from controller to datapath
  typedef struct packed {
    logic    load;
    logic    div_step;
    logic    red_step;
    logic    probe_init;
    logic    rd;
    logic    advance;
    logic    wr;
    logic    clr_step;
    logic    out_load;
    status_t out_status;
  } cmd_t;

  // status from datapath to controller
  typedef struct packed {
    logic is_search;
    logic div_done;
    logic red_done;
    logic used;
    logic match;
    logic last;
    logic out_busy;
    logic clr_last;
  } stat_t;

endpackage

FILE: rtl/hltp_dp.sv
// datapath: divider, slot memory, probe counters and result register
module hltp_dp #(
  parameter int TABLE_SIZE = hltp_pkg::DEF_TABLE_SIZE,
  parameter int KEY_BITS   = hltp_pkg::DEF_KEY_BITS
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  hltp_pkg::cmd_t                cmd,
  output hltp_pkg::stat_t               stat,
  input  logic                          in_tuser,
  input  logic [hltp_pkg::KEY_FW-1:0]   in_tdata,
  input  logic                          cfg_valid,
  input  logic [hltp_pkg::DIV_W-1:0]    cfg_data,
  output logic                          out_tvalid,
  input  logic                          out_tready,
  output logic [1:0]                    out_tuser,
  output logic [hltp_pkg::OUT_DW-1:0]   out_tdata
);

  localparam int SLOT_W = $clog2(TABLE_SIZE);
  localparam int CNT_W  = $clog2(TABLE_SIZE + 1);
  localparam int DCW    = $clog2(KEY_BITS + 1);
  localparam int WORD_W = KEY_BITS + hltp_pkg::PROBE_FW + 1;
  localparam int USED_B = WORD_W - 1;

  logic [hltp_pkg::DIV_W-1:0] div_cfg_r;
  logic [hltp_pkg::DIV_W-1:0] divisor;
  logic                       op_r;
  logic [KEY_BITS-1:0]        key_r;
  logic [KEY_BITS-1:0]        key_sh_r;
  logic [DCW-1:0]             div_cnt_r;
  logic [hltp_pkg::DIV_W-1:0] rem_r;
  logic [hltp_pkg::DIV_W:0]   rem_try;
  logic [SLOT_W-1:0]          pos_r;
  logic [CNT_W-1:0]           n_r;
  logic [SLOT_W-1:0]          clr_r;
  logic [WORD_W-1:0]          mem [TABLE_SIZE];
  logic [WORD_W-1:0]          rd_q_r;
  logic [SLOT_W-1:0]          wr_addr;
  logic [WORD_W-1:0]          wr_data;
  logic                       out_valid_r;
  hltp_pkg::status_t          out_status_r;
  logic [hltp_pkg::SLOT_FW-1:0]  out_slot_r;
  logic [hltp_pkg::PROBE_FW-1:0] out_probe_r;

  assign divisor = (div_cfg_r == '0) ? hltp_pkg::DIV_W'(1) : div_cfg_r;
  // restoring division step, msb of the key first
  assign rem_try = {rem_r, key_sh_r[KEY_BITS-1]};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      div_cfg_r <= hltp_pkg::DIV_RESET;
    end else if (cfg_valid) begin
      div_cfg_r <= cfg_data;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      op_r      <= in_tuser;
      key_r     <= KEY_BITS'(in_tdata);
      key_sh_r  <= KEY_BITS'(in_tdata);
      div_cnt_r <= DCW'(KEY_BITS);
      rem_r     <= '0;
    end else if (cmd.div_step) begin
      key_sh_r  <= key_sh_r << 1;
      div_cnt_r <= div_cnt_r - DCW'(1);
      if (rem_try >= {1'b0, divisor}) begin
        rem_r <= hltp_pkg::DIV_W'(rem_try - {1'b0, divisor});
      end else begin
        rem_r <= hltp_pkg::DIV_W'(rem_try);
      end
    end else if (cmd.red_step) begin
      rem_r <= rem_r - hltp_pkg::DIV_W'(TABLE_SIZE);
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.probe_init) begin
      pos_r <= SLOT_W'(rem_r);
      n_r   <= CNT_W'(1);
    end else if (cmd.advance) begin
      pos_r <= (pos_r == SLOT_W'(TABLE_SIZE - 1)) ? '0 : pos_r + SLOT_W'(1);
      n_r   <= n_r + CNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      clr_r <= '0;
    end else if (cmd.clr_step) begin
      clr_r <= clr_r + SLOT_W'(1);
    end
  end

  // word: used mark, probe length, key
  assign wr_addr = cmd.clr_step ? clr_r : pos_r;
  assign wr_data = cmd.clr_step ? '0 : {1'b1, hltp_pkg::PROBE_FW'(n_r), key_r};

  always_ff @(posedge clk) begin
    if (cmd.wr || cmd.clr_step) begin
      mem[wr_addr] <= wr_data;
    end
    if (cmd.rd) begin
      rd_q_r <= mem[pos_r];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.out_load) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      out_status_r <= cmd.out_status;
      out_probe_r  <= hltp_pkg::PROBE_FW'(n_r);
      if (cmd.out_status == hltp_pkg::ST_INSERTED || cmd.out_status == hltp_pkg::ST_FOUND) begin
        out_slot_r <= hltp_pkg::SLOT_FW'(pos_r);
      end else begin
        out_slot_r <= '0;
      end
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tuser  = out_status_r;
  assign out_tdata  = {{(hltp_pkg::OUT_DW - hltp_pkg::PROBE_FW - hltp_pkg::SLOT_FW){1'b0}},
                       out_probe_r, out_slot_r};

  always_comb begin
    stat.is_search = (op_r == hltp_pkg::CMD_SEARCH);
    stat.div_done  = (div_cnt_r == '0);
    stat.red_done  = (32'(rem_r) < 32'(TABLE_SIZE));
    stat.used      = rd_q_r[USED_B];
    stat.match     = (rd_q_r[KEY_BITS-1:0] == key_r);
    stat.last      = (n_r == CNT_W'(TABLE_SIZE));
    stat.out_busy  = out_valid_r && !out_tready;
    stat.clr_last  = (clr_r == SLOT_W'(TABLE_SIZE - 1));
  end

endmodule

FILE: rtl/hltp_ctrl.sv
// controller state machine of the hash table
module hltp_ctrl (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            in_tvalid,
  output logic            in_tready,
  input  hltp_pkg::stat_t stat,
  output hltp_pkg::cmd_t  cmd
);

  typedef enum logic [2:0] {
    S_CLEAR,
    S_IDLE,
    S_DIV,
    S_RED,
    S_READ,
    S_CHECK
  } state_t;

  state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_CLEAR;
    end else begin
      state_r <= state_nxt;
    end
  end

  assign in_tready = (state_r == S_IDLE);

  always_comb begin
    state_nxt = state_r;
    cmd = '0;
    cmd.out_status = hltp_pkg::ST_INSERTED;
    unique case (state_r)
      S_CLEAR: begin
        cmd.clr_step = 1'b1;
        if (stat.clr_last) state_nxt = S_IDLE;
      end
      S_IDLE: begin
        if (in_tvalid) begin
          cmd.load  = 1'b1;
          state_nxt = S_DIV;
        end
      end
      S_DIV: begin
        if (stat.div_done) begin
          state_nxt = S_RED;
        end else begin
          cmd.div_step = 1'b1;
        end
      end
      S_RED: begin
        // fold the remainder into the table
        if (stat.red_done) begin
          cmd.probe_init = 1'b1;
          state_nxt      = S_READ;
        end else begin
          cmd.red_step = 1'b1;
        end
      end
      S_READ: begin
        cmd.rd    = 1'b1;
        state_nxt = S_CHECK;
      end
      S_CHECK: begin
        if (!stat.is_search) begin
          if (!stat.used) begin
            if (!stat.out_busy) begin
              cmd.wr       = 1'b1;
              cmd.out_load = 1'b1;
              state_nxt    = S_IDLE;
            end
          end else if (stat.last) begin
            cmd.out_status = hltp_pkg::ST_FULL;
            if (!stat.out_busy) begin
              cmd.out_load = 1'b1;
              state_nxt    = S_IDLE;
            end
          end else begin
            cmd.advance = 1'b1;
            state_nxt   = S_READ;
          end
        end else begin
          if (!stat.used || (!stat.match && stat.last)) begin
            cmd.out_status = hltp_pkg::ST_NOT_FOUND;
            if (!stat.out_busy) begin
              cmd.out_load = 1'b1;
              state_nxt    = S_IDLE;
            end
          end else if (stat.match) begin
            cmd.out_status = hltp_pkg::ST_FOUND;
            if (!stat.out_busy) begin
              cmd.out_load = 1'b1;
              state_nxt    = S_IDLE;
            end
          end else begin
            cmd.advance = 1'b1;
            state_nxt   = S_READ;
          end
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

endmodule

FILE: rtl/hash_table_linear_probe.sv
// top level of the linear probing hash table
// Open addressing hash table with linear probing and wrap-around.
// in channel: in_tuser is the operation (insert or search), in_tdata the key.
// One request is taken at a time; in_tready is high only while the block idles.
// out channel: one result per request, out_tuser is the status (inserted,
// found, not found, table full), out_tdata holds slot and probe count.
// cfg channel: cfg_data is the divisor of the home slot hash, always ready;
// write it only while no request is in flight. Reset value is 13.
// Steps: the accepting cycle, the bit-serial remainder unit, folding the remainder
// below TABLE_SIZE, then per probed slot a registered memory read and a compare;
// the compare cycle loads the result register.
// The result register frees the controller: a new request is taken while the
// previous result still waits; a request finishing while that result is still
// unaccepted holds its last probe until the output register is free.
// Reset: a clearing pass writes one slot per cycle over all TABLE_SIZE slots, with
// in_tready low; configuration writes are taken during it.
module hash_table_linear_probe #(
  parameter int TABLE_SIZE = hltp_pkg::DEF_TABLE_SIZE,
  parameter int KEY_BITS   = hltp_pkg::DEF_KEY_BITS
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        in_tvalid,
  output logic                        in_tready,
  input  logic                        in_tuser,   // cmd
  input  logic [hltp_pkg::KEY_FW-1:0] in_tdata,   // key
  output logic                        out_tvalid,
  input  logic                        out_tready,
  output logic [1:0]                  out_tuser,  // status
  output logic [hltp_pkg::OUT_DW-1:0] out_tdata,  // slot[3:0], probe_count[8:4], zeros
  input  logic                        cfg_valid,
  output logic                        cfg_ready,
  input  logic [hltp_pkg::DIV_W-1:0]  cfg_data    // hash_divisor
);

  hltp_pkg::cmd_t  cmd;
  hltp_pkg::stat_t stat;

  assign cfg_ready = 1'b1;

  hltp_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .stat      (stat),
    .cmd       (cmd)
  );

  hltp_dp #(
    .TABLE_SIZE (TABLE_SIZE),
    .KEY_BITS   (KEY_BITS)
  ) u_dp (
    .clk        (clk),
    .rst_n      (rst_n),
    .cmd        (cmd),
    .stat       (stat),
    .in_tuser   (in_tuser),
    .in_tdata   (in_tdata),
    .cfg_valid  (cfg_valid),
    .cfg_data   (cfg_data),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tuser  (out_tuser),
    .out_tdata  (out_tdata)
  );

endmodule

FILE: sim/tb_top.sv
// testbench of the linear probing hash table: directed requests, then random phases
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int TABLE_SLOTS  = hltp_pkg::DEF_TABLE_SIZE;
  localparam int RANDOM_ITEMS = 1080;
  localparam int HOLD_CYCLES  = 400;
  localparam int TAIL_CYCLES  = 80;
  localparam int LIMIT_CYCLES = 400000;

  typedef struct packed {
    hltp_pkg::status_t             status;
    logic [hltp_pkg::SLOT_FW-1:0]  slot;
    logic [hltp_pkg::PROBE_FW-1:0] probes;
  } lookup_result_t;

  typedef enum logic { ROW_REQ, ROW_CFG } row_kind_t;

  typedef struct packed {
    row_kind_t                   kind;
    hltp_pkg::op_t               op;
    logic [hltp_pkg::KEY_FW-1:0] value;   // key, or divisor for a config row
    logic                        typed;
    lookup_result_t              want;
  } plan_row_t;

  localparam lookup_result_t UNTYPED = '{hltp_pkg::ST_INSERTED, 4'd0, 5'd0};

  logic                          clk = 1'b0;
  logic                          rst_n = 1'b0;
  logic                          in_tvalid = 1'b0;
  logic                          in_tready;
  logic                          in_tuser = 1'b0;   // cmd
  logic [hltp_pkg::KEY_FW-1:0]   in_tdata = '0;     // key
  logic                          out_tvalid;
  logic                          out_tready = 1'b0;
  logic [1:0]                    out_tuser;         // status
  logic [hltp_pkg::OUT_DW-1:0]   out_tdata;         // slot[3:0], probe_count[8:4], zeros
  logic                          cfg_valid = 1'b0;
  logic                          cfg_ready;
  logic [hltp_pkg::DIV_W-1:0]    cfg_data = '0;     // hash_divisor

  // predictor copy of the table and the divisor
  logic [hltp_pkg::KEY_FW-1:0]   stored_key [TABLE_SLOTS];
  logic                          slot_taken [TABLE_SLOTS] = '{default: 1'b0};
  logic [hltp_pkg::DIV_W-1:0]    divisor = hltp_pkg::DIV_RESET;

  lookup_result_t      pending_q [$];
  int                  mismatches = 0;
  int                  cycles = 0;
  logic                quiet = 1'b0;
  int                  hold_ticket = 0;
  int                  hold_seen = 0;
  int                  hold_left = 0;

  plan_row_t plan [28] = '{
    '{ROW_REQ, hltp_pkg::CMD_SEARCH, 16'h0000, 1'b1, '{hltp_pkg::ST_NOT_FOUND, 4'd0, 5'd1}},
    '{ROW_REQ, hltp_pkg::CMD_INSERT, 16'hFFFF, 1'b1, '{hltp_pkg::ST_INSERTED, 4'd2, 5'd1}},
    '{ROW_REQ, hltp_pkg::CMD_INSERT, 16'h0000, 1'b1, '{hltp_pkg::ST_INSERTED, 4'd0, 5'd1}},
    '{ROW_REQ, hltp_pkg::CMD_INSERT, 16'd13,   1'b0, UNTYPED},
    '{ROW_REQ, hltp_pkg::CMD_INSERT, 16'd13,   1'b0, UNTYPED},   // duplicate key
    '{ROW_REQ, hltp_pkg::CMD_SEARCH, 16'd13,   1'b0, UNTYPED},
    '{ROW_REQ, hltp_pkg::CMD_SEARCH, 16'd26,   1'b0, UNTYPED},   // miss at a free slot
    '{ROW_REQ, hltp_pkg::CMD_INSERT, 16'd12,   1'b0, UNTYPED},
    '{ROW_CFG, hltp_pkg::CMD_INSERT, 16'd0,    1'b0, UNTYPED},   // zero divisor acts as one
    '{ROW_REQ, hltp_pkg::CMD_INSERT, 16'h5555, 1'b0, UNTYPED},
    '{ROW_REQ, hltp_pkg::CMD_SEARCH, 16'h5555, 1'b0, UNTYPED},
    '{ROW_CFG, hltp_pkg::CMD_INSERT, 16'd31,   1'b0, UNTYPED},   // remainder above the table
    '{ROW_REQ, hltp_pkg::CMD_INSERT, 16'd30,   1'b0, UNTYPED},
    '{ROW_REQ, hltp_pkg::CMD_INSERT, 16'd15,   1'b0, UNTYPED},
    '{ROW_REQ, hltp_pkg::CMD_INSERT, 16'd46,   1'b0, UNTYPED},   // wraps past the last slot
    '{ROW_REQ, hltp_pkg::CMD_SEARCH, 16'd46,   1'b0, UNTYPED},
    '{ROW_CFG, hltp_pkg::CMD_INSERT, 16'd16,   1'b0, UNTYPED},
    '{ROW_REQ, hltp_pkg::CMD_INSERT, 16'hFFFF, 1'b0, UNTYPED},
    '{ROW_CFG, hltp_pkg::CMD_INSERT, 16'd1,    1'b0, UNTYPED},
    '{ROW_REQ, hltp_pkg::CMD_INSERT, 16'h8000, 1'b0, UNTYPED},
    '{ROW_REQ, hltp_pkg::CMD_INSERT, 16'h0001, 1'b0, UNTYPED},
    '{ROW_REQ, hltp_pkg::CMD_INSERT, 16'h7FFF, 1'b0, UNTYPED},
    '{ROW_REQ, hltp_pkg::CMD_INSERT, 16'h00FF, 1'b0, UNTYPED},
    '{ROW_REQ, hltp_pkg::CMD_INSERT, 16'hFF00, 1'b0, UNTYPED},
    '{ROW_REQ, hltp_pkg::CMD_INSERT, 16'h1234, 1'b0, UNTYPED},   // last free slot
    '{ROW_REQ, hltp_pkg::CMD_INSERT, 16'hAAAA, 1'b1, '{hltp_pkg::ST_FULL, 4'd0, 5'd16}},
    '{ROW_REQ, hltp_pkg::CMD_SEARCH, 16'hBEEF, 1'b1, '{hltp_pkg::ST_NOT_FOUND, 4'd0, 5'd16}},
    '{ROW_REQ, hltp_pkg::CMD_SEARCH, 16'h1234, 1'b0, UNTYPED}
  };

  hash_table_linear_probe u_top (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tuser   (in_tuser),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tuser  (out_tuser),
    .out_tdata  (out_tdata),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_data   (cfg_data)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles == LIMIT_CYCLES) begin
      $display("tb_top: FAIL");
      $finish;
    end
  end

  // walks the probe path from the home slot, updating the table on insert
  function automatic lookup_result_t probe_table(input hltp_pkg::op_t op,
                                                 input logic [hltp_pkg::KEY_FW-1:0] key);
    int unsigned base;
    int unsigned pos;
    base = (divisor == 0) ? 1 : divisor;
    pos = (key % base) % TABLE_SLOTS;
    for (int n = 1; n <= TABLE_SLOTS; n++) begin
      if (!slot_taken[pos]) begin
        if (op == hltp_pkg::CMD_INSERT) begin
          slot_taken[pos] = 1'b1;
          stored_key[pos] = key;
          return '{hltp_pkg::ST_INSERTED, pos[3:0], n[4:0]};
        end
        return '{hltp_pkg::ST_NOT_FOUND, 4'd0, n[4:0]};
      end
      if (op == hltp_pkg::CMD_SEARCH && stored_key[pos] == key)
        return '{hltp_pkg::ST_FOUND, pos[3:0], n[4:0]};
      pos = (pos + 1) % TABLE_SLOTS;
    end
    if (op == hltp_pkg::CMD_INSERT)
      return '{hltp_pkg::ST_FULL, 4'd0, 5'd16};
    return '{hltp_pkg::ST_NOT_FOUND, 4'd0, 5'd16};
  endfunction

  task automatic issue(input hltp_pkg::op_t op, input logic [hltp_pkg::KEY_FW-1:0] key,
                       input logic typed, input lookup_result_t want);
    lookup_result_t got;
    if (!quiet && $urandom_range(99) < 8) begin
      in_tvalid <= 1'b0;
      repeat ($urandom_range(1, 60)) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tuser  <= op;
    in_tdata  <= key;
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    got = probe_table(op, key);
    pending_q.push_back(typed ? want : got);
  endtask

  // drop the offer and wait until every request has its result back
  task automatic settle();
    in_tvalid <= 1'b0;
    while (pending_q.size() != 0) @(posedge clk);
  endtask

  task automatic write_divisor(input logic [hltp_pkg::DIV_W-1:0] value);
    cfg_valid <= 1'b1;
    cfg_data  <= value;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid <= 1'b0;
    divisor = value;
  endtask

  // result side: random stalls, plus one long hold-off on request
  always @(posedge clk) begin
    if (hold_ticket != hold_seen) begin
      hold_seen  <= hold_ticket;
      hold_left  <= HOLD_CYCLES;
      out_tready <= 1'b0;
    end else if (hold_left != 0) begin
      hold_left  <= hold_left - 1;
      out_tready <= 1'b0;
    end else begin
      out_tready <= quiet || ($urandom_range(99) >= 8);
    end
  end

  always @(posedge clk) begin
    lookup_result_t want;
    if (rst_n && out_tvalid && out_tready) begin
      if (pending_q.size() == 0) begin
        $error("result with nothing pending: status %0d tdata %h", out_tuser, out_tdata);
        mismatches++;
      end else begin
        want = pending_q.pop_front();
        if (out_tuser !== want.status) begin
          $error("status: expected %0d, got %0d", want.status, out_tuser);
          mismatches++;
        end
        if (out_tdata[3:0] !== want.slot) begin
          $error("slot: expected %0d, got %0d", want.slot, out_tdata[3:0]);
          mismatches++;
        end
        if (out_tdata[8:4] !== want.probes) begin
          $error("probe_count: expected %0d, got %0d", want.probes, out_tdata[8:4]);
          mismatches++;
        end
      end
    end
  end

  initial begin
    int issued;
    int phase;
    int phase_len;
    int pick;
    logic [hltp_pkg::KEY_FW-1:0] key;
    logic [hltp_pkg::DIV_W-1:0] new_div;
    issued = 0;
    phase = 0;
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;

    foreach (plan[i]) begin
      if (plan[i].kind == ROW_CFG) begin
        settle();
        write_divisor(plan[i].value[hltp_pkg::DIV_W-1:0]);
      end else begin
        issue(plan[i].op, plan[i].value, plan[i].typed, plan[i].want);
      end
    end

    while (issued < RANDOM_ITEMS) begin
      settle();
      case ($urandom_range(5))
        0:       new_div = 5'd0;
        1:       new_div = 5'd1;
        2:       new_div = 5'd16;
        3:       new_div = 5'd31;
        default: new_div = hltp_pkg::DIV_W'($urandom_range(31));
      endcase
      write_divisor(new_div);
      quiet <= (phase == 0);
      if (phase == 1)
        hold_ticket <= hold_ticket + 1;
      phase_len = $urandom_range(40, 120);
      for (int k = 0; k < phase_len && issued < RANDOM_ITEMS; k++) begin
        pick = $urandom_range(99);
        key = hltp_pkg::KEY_FW'($urandom_range(16'hFFFF));
        if (pick < 55) begin
          pick = $urandom_range(TABLE_SLOTS - 1);
          if (slot_taken[pick])
            key = stored_key[pick];
          issue(hltp_pkg::CMD_SEARCH, key, 1'b0, UNTYPED);
        end else if (pick < 70) begin
          issue(hltp_pkg::CMD_SEARCH, key, 1'b0, UNTYPED);
        end else if (pick < 80) begin
          // near miss: a stored key with one bit flipped, if the picked slot is used
          pick = $urandom_range(TABLE_SLOTS - 1);
          if (slot_taken[pick])
            key = stored_key[pick] ^ (16'h1 << $urandom_range(15));
          issue(hltp_pkg::CMD_SEARCH, key, 1'b0, UNTYPED);
        end else begin
          issue(hltp_pkg::CMD_INSERT, key, 1'b0, UNTYPED);
        end
        issued++;
      end
      phase++;
    end

    settle();
    repeat (TAIL_CYCLES) @(posedge clk);
    if (mismatches == 0)
      $display("tb_top: PASS");
    else
      $display("tb_top: FAIL");
    $finish;
  end

endmodule

FILE: files.f
rtl/hltp_pkg.sv
rtl/hltp_dp.sv
rtl/hltp_ctrl.sv
rtl/hash_table_linear_probe.sv
sim/tb_top.sv
